FILE: rtl/rvx_pkg.sv
package rvx_pkg;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpSystem = 7'h73;
  localparam logic [6:0] OpFence  = 7'h0f;

  localparam logic [6:0]  F7Base   = 7'h00;
  localparam logic [6:0]  F7Alt    = 7'h20;
  localparam logic [6:0]  F7Mul    = 7'h01;
  localparam logic [31:0] EcallWord = 32'h0000_0073;

  localparam logic [2:0] F3Mul    = 3'd0;
  localparam logic [2:0] F3Mulh   = 3'd1;
  localparam logic [2:0] F3Mulhsu = 3'd2;
  localparam logic [2:0] F3Mulhu  = 3'd3;
  localparam logic [2:0] F3Div    = 3'd4;
  localparam logic [2:0] F3Divu   = 3'd5;
  localparam logic [2:0] F3Rem    = 3'd6;
  localparam logic [2:0] F3Remu   = 3'd7;

  localparam int unsigned XLen = 32;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    VAL_NONE, VAL_IMMU, VAL_AUIPC, VAL_LINK, VAL_ALU, VAL_MUL, VAL_DIV
  } val_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic [4:0]  rd_index;
    logic        rd_write;
    logic signed [31:0] rd_value;
    logic [31:0] mem_address;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic        load_unsigned;
    logic signed [31:0] store_data;
    logic [31:0] next_pc;
    logic        ecall;
    logic        illegal;
  } out_t;

  typedef struct packed {
    val_e        kind;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt;
    logic        use_imm;
    logic        is_br;
    logic        is_jal;
    logic        is_jalr;
    logic        wr;
    logic        rdm;
    logic        wrm;
    logic        lu;
    logic        ec;
    logic        bad;
    logic [1:0]  size;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
  } dec_t;

  typedef struct packed {
    logic        en;
    logic        want_rem;
    logic        neg_res;
    logic        ovr;
    logic [31:0] ovr_val;
  } divctl_t;

  typedef struct packed {
    out_t        res;
    divctl_t     dctl;
    logic [31:0] rem;
    logic [31:0] dq;
    logic [31:0] dv;
  } pipe_t;

endpackage

FILE: rtl/rvx_decode.sv
module rvx_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rvx_pkg::in_t  data_i,
  output logic          ready_o,
  output logic          valid_o,
  output rvx_pkg::dec_t data_o,
  input  logic          ready_i
);

  logic          v_q;
  rvx_pkg::dec_t d_q, d_d;
  logic [31:0]   ins;
  logic [6:0]    op, f7;
  logic [2:0]    f3;

  assign ins = data_i.instruction;
  assign op  = ins[6:0];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];

  always_comb begin
    d_d = '0;
    d_d.kind = rvx_pkg::VAL_NONE;
    d_d.rd = ins[11:7];
    d_d.f3 = f3;
    d_d.pc = data_i.pc;
    d_d.a  = data_i.rs1_value;
    d_d.b  = data_i.rs2_value;
    d_d.imm = {{20{ins[31]}}, ins[31:20]};
    case (op)
      rvx_pkg::OpLui: begin
        d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_IMMU; d_d.imm = {ins[31:12], 12'b0};
      end
      rvx_pkg::OpAuipc: begin
        d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_AUIPC; d_d.imm = {ins[31:12], 12'b0};
      end
      rvx_pkg::OpJal: begin
        d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_LINK; d_d.is_jal = 1'b1;
        d_d.imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      rvx_pkg::OpJalr: begin
        if (f3 != 3'd0) begin
          d_d.bad = 1'b1;
        end else begin
          d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_LINK; d_d.is_jalr = 1'b1;
        end
      end
      rvx_pkg::OpBranch: begin
        d_d.imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        if (f3 == 3'd2 || f3 == 3'd3) d_d.bad = 1'b1;
        else d_d.is_br = 1'b1;
      end
      rvx_pkg::OpLoad: begin
        if (f3 == 3'd3 || f3 > 3'd5) begin
          d_d.bad = 1'b1;
        end else begin
          d_d.wr = 1'b1; d_d.rdm = 1'b1; d_d.size = f3[1:0]; d_d.lu = f3[2];
        end
      end
      rvx_pkg::OpStore: begin
        d_d.imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        if (f3 > 3'd2) begin
          d_d.bad = 1'b1;
        end else begin
          d_d.wrm = 1'b1; d_d.size = f3[1:0];
        end
      end
      rvx_pkg::OpImm: begin
        if (f3 == 3'd1 && f7 != rvx_pkg::F7Base) begin
          d_d.bad = 1'b1;
        end else if (f3 == 3'd5 && f7 != rvx_pkg::F7Base && f7 != rvx_pkg::F7Alt) begin
          d_d.bad = 1'b1;
        end else begin
          d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_ALU; d_d.use_imm = 1'b1;
          d_d.alt = (f3 == 3'd5) && (f7 == rvx_pkg::F7Alt);
        end
      end
      rvx_pkg::OpReg: begin
        if (f7 == rvx_pkg::F7Mul) begin
          d_d.wr = 1'b1;
          d_d.kind = f3[2] ? rvx_pkg::VAL_DIV : rvx_pkg::VAL_MUL;
        end else if (f7 == rvx_pkg::F7Base) begin
          d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_ALU;
        end else if (f7 == rvx_pkg::F7Alt && (f3 == 3'd0 || f3 == 3'd5)) begin
          d_d.wr = 1'b1; d_d.kind = rvx_pkg::VAL_ALU; d_d.alt = 1'b1;
        end else begin
          d_d.bad = 1'b1;
        end
      end
      rvx_pkg::OpSystem: begin
        if (ins == rvx_pkg::EcallWord) d_d.ec = 1'b1;
        else d_d.bad = 1'b1;
      end
      rvx_pkg::OpFence: begin
        if (f3 != 3'd0) d_d.bad = 1'b1;
      end
      default: d_d.bad = 1'b1;
    endcase
    if (d_d.bad) begin
      d_d.wr = 1'b0; d_d.rdm = 1'b0; d_d.wrm = 1'b0; d_d.lu = 1'b0; d_d.ec = 1'b0;
      d_d.size = 2'd0; d_d.kind = rvx_pkg::VAL_NONE;
      d_d.is_br = 1'b0; d_d.is_jal = 1'b0; d_d.is_jalr = 1'b0;
    end
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

endmodule

FILE: rtl/rvx_exec.sv
module rvx_exec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rvx_pkg::dec_t  data_i,
  output logic           ready_o,
  output logic           valid_o,
  output rvx_pkg::pipe_t data_o,
  input  logic           ready_i
);

  logic           v_q;
  rvx_pkg::pipe_t p_q, p_d;
  logic [31:0]    a, b, opb, alu, mval, sum_ai, pc4;
  logic [4:0]     sh;
  logic           eq, lts, ltu, taken, a_sgn, b_sgn, a_neg, b_neg, dsig;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [31:0]    ua, ub, val;

  assign a   = data_i.a;
  assign b   = data_i.b;
  assign opb = data_i.use_imm ? data_i.imm : b;
  assign sh  = opb[4:0];
  assign eq  = (a == b);
  assign lts = $signed(a) < $signed(opb);
  assign ltu = a < opb;
  assign sum_ai = a + data_i.imm;
  assign pc4 = data_i.pc + 32'd4;

  always_comb begin
    case (data_i.f3)
      3'd0: alu = data_i.alt ? a - opb : a + opb;
      3'd1: alu = a << sh;
      3'd2: alu = {31'b0, lts};
      3'd3: alu = {31'b0, ltu};
      3'd4: alu = a ^ opb;
      3'd5: alu = data_i.alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | opb;
      default: alu = a & opb;
    endcase
  end

  // High products need a 33-bit signed operand so unsigned values keep their magnitude.
  assign a_sgn = (data_i.f3 == rvx_pkg::F3Mulh) || (data_i.f3 == rvx_pkg::F3Mulhsu);
  assign b_sgn = (data_i.f3 == rvx_pkg::F3Mulh);
  assign ma    = $signed({a_sgn & a[31], a});
  assign mb    = $signed({b_sgn & b[31], b});
  assign prod  = ma * mb;
  assign mval  = (data_i.f3 == rvx_pkg::F3Mul) ? prod[31:0] : prod[63:32];

  always_comb begin
    case (data_i.f3)
      3'd0: taken = eq;
      3'd1: taken = !eq;
      3'd4: taken = $signed(a) < $signed(b);
      3'd5: taken = !($signed(a) < $signed(b));
      3'd6: taken = a < b;
      3'd7: taken = !(a < b);
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    case (data_i.kind)
      rvx_pkg::VAL_IMMU:  val = data_i.imm;
      rvx_pkg::VAL_AUIPC: val = data_i.pc + data_i.imm;
      rvx_pkg::VAL_LINK:  val = pc4;
      rvx_pkg::VAL_ALU:   val = alu;
      rvx_pkg::VAL_MUL:   val = mval;
      default:            val = 32'd0;
    endcase
  end

  assign dsig  = !data_i.f3[0];
  assign a_neg = dsig && a[31];
  assign b_neg = dsig && b[31];
  assign ua    = a_neg ? -a : a;
  assign ub    = b_neg ? -b : b;

  always_comb begin
    p_d = '0;
    p_d.res.rd_index = data_i.rd;
    p_d.res.rd_write = data_i.wr && (data_i.rd != 5'd0);
    p_d.res.rd_value = (data_i.wr && !data_i.rdm && data_i.rd != 5'd0) ? val : 32'd0;
    p_d.res.mem_address = (data_i.rdm || data_i.wrm) ? sum_ai : 32'd0;
    p_d.res.mem_read = data_i.rdm;
    p_d.res.mem_write = data_i.wrm;
    p_d.res.mem_size = data_i.size;
    p_d.res.load_unsigned = data_i.lu;
    p_d.res.store_data = data_i.wrm ? b : 32'd0;
    if (data_i.is_jal || (data_i.is_br && taken)) p_d.res.next_pc = data_i.pc + data_i.imm;
    else if (data_i.is_jalr) p_d.res.next_pc = {sum_ai[31:1], 1'b0};
    else p_d.res.next_pc = pc4;
    p_d.res.ecall = data_i.ec;
    p_d.res.illegal = data_i.bad;
    p_d.dctl.en = (data_i.kind == rvx_pkg::VAL_DIV) && p_d.res.rd_write;
    p_d.dctl.want_rem = data_i.f3[1];
    p_d.dctl.neg_res = data_i.f3[1] ? a_neg : (a_neg ^ b_neg);
    p_d.dctl.ovr = (b == 32'd0);
    p_d.dctl.ovr_val = data_i.f3[1] ? a : 32'hFFFF_FFFF;
    p_d.rem = 32'd0;
    p_d.dq  = ua;
    p_d.dv  = ub;
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q <= p_d;
    end
  end

endmodule

FILE: rtl/rvx_div_stage.sv
module rvx_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rvx_pkg::pipe_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  output rvx_pkg::pipe_t data_o,
  input  logic           ready_i
);

  logic           v_q;
  rvx_pkg::pipe_t p_q, p_d;
  logic [32:0]    t, diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign t    = {data_i.rem, data_i.dq[31]};
  assign diff = t - {1'b0, data_i.dv};

  always_comb begin
    p_d = data_i;
    if (!diff[32]) begin
      p_d.rem = diff[31:0];
    end else begin
      p_d.rem = t[31:0];
    end
    p_d.dq = {data_i.dq[30:0], !diff[32]};
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q <= p_d;
    end
  end

endmodule

FILE: rtl/rv32im_decode_execute_core.sv
// Stages: decode, execute, 32 divider steps and an output stage, each registered.
// Throughput: one beat per cycle for every instruction, divides included, while the
// output side does not stall, set by the fully pipelined one-bit-per-stage divider.
// Reset: rst_ni clears all stage valid bits asynchronously; no payload is reset.
module rv32im_decode_execute_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rvx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rvx_pkg::out_t out_data_o
);

  // Decode stage: formats the immediate and classifies the instruction.
  logic          dec_v, dec_rdy, in_rdy;
  rvx_pkg::dec_t dec_d;

  rvx_decode u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ready_o (in_rdy),
    .valid_o (dec_v),
    .data_o  (dec_d),
    .ready_i (dec_rdy)
  );

  assign in_stall_o = !in_rdy;

  // The divider chain runs for every beat so that all results keep one fixed
  // order and latency; only division results use its outcome. It needs one
  // step for each quotient bit.
  logic           pv   [rvx_pkg::DivSteps+1];
  logic           prdy [rvx_pkg::DivSteps+1];
  rvx_pkg::pipe_t pd   [rvx_pkg::DivSteps+1];

  rvx_exec u_exe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_v),
    .data_i  (dec_d),
    .ready_o (dec_rdy),
    .valid_o (pv[0]),
    .data_o  (pd[0]),
    .ready_i (prdy[0])
  );

  for (genvar k = 0; k < rvx_pkg::DivSteps; k++) begin : g_div
    rvx_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pv[k]),
      .data_i  (pd[k]),
      .ready_o (prdy[k]),
      .valid_o (pv[k+1]),
      .data_o  (pd[k+1]),
      .ready_i (prdy[k+1])
    );
  end

  // Output stage: the quotient or remainder gets its sign and the special
  // cases for a zero divisor before the beat is offered downstream.
  logic            out_v_q;
  rvx_pkg::out_t   out_q, out_d;
  rvx_pkg::pipe_t  last;
  logic [31:0]     mag, sgn;

  assign last = pd[rvx_pkg::DivSteps];
  assign mag  = last.dctl.want_rem ? last.rem : last.dq;
  assign sgn  = last.dctl.neg_res ? -mag : mag;

  always_comb begin
    out_d = last.res;
    if (last.dctl.en) begin
      out_d.rd_value = last.dctl.ovr ? last.dctl.ovr_val : sgn;
    end
  end

  assign prdy[rvx_pkg::DivSteps] = !out_v_q || !out_stall_i;
  assign out_valid_o    = out_v_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (prdy[rvx_pkg::DivSteps]) begin
      out_v_q <= pv[rvx_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prdy[rvx_pkg::DivSteps] && pv[rvx_pkg::DivSteps]) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.illegal |-> !out_data_o.rd_write && !out_data_o.mem_read
      && !out_data_o.mem_write && !out_data_o.ecall)
    else $error("illegal instruction produced side effects");
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.mem_read && out_data_o.mem_write))
    else $error("load and store requested together");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> dec_v)
    else $error("accepted beat missing from decode stage");
  a_no_rd_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.rd_write |-> out_data_o.rd_value == 32'd0)
    else $error("value reported without register write");
`endif

endmodule
